/* design/spwm_pkg.sv */
package spwm_pkg;

    // Default structural parameters.
    localparam int DEF_SINE_DEPTH = 1024;
    localparam int DEF_TICK_WIDTH = 32;

    // Phase accumulator geometry.
    localparam int PHASE_BITS = 40;
    localparam int LOW_BITS   = 20;
    localparam int TICK_EXT_W = 48;

    // Field widths.
    localparam int CP_W   = 16;
    localparam int PS_W   = 32;
    localparam int ZB_W   = 15;
    localparam int MAG_W  = 15;
    localparam int M_W    = 16;
    localparam int DUTY_W = 16;
    localparam int POL_W  = 2;
    localparam int TON_W  = 32;

    // Square root and divide datapaths.
    localparam int SQ_VW      = 56;
    localparam int ROOT_W     = SQ_VW / 2;
    localparam int NUM_W      = 32;
    localparam int SQRT_STEP  = 2;
    localparam int DIV_STEP   = 4;

    localparam logic [DUTY_W-1:0] DUTY_MAX = 16'd65470;

    // Polarity codes.
    localparam logic [POL_W-1:0] POL_ZERO = 2'd0;
    localparam logic [POL_W-1:0] POL_POS  = 2'd1;
    localparam logic [POL_W-1:0] POL_NEG  = 2'd2;

    // Configuration port.
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_CARRIER_PERIOD = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DEAD_TIME      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_S1_DELAY       = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_PHASE_STEP     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_PEAK_RATIO     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_ZERO_BAND      = 3'd5;

    // Register reset values.
    localparam logic [CP_W-1:0] RST_CARRIER_PERIOD = 16'd2000;
    localparam logic [CP_W-1:0] RST_DEAD_TIME      = 16'd30;
    localparam logic [CP_W-1:0] RST_S1_DELAY       = 16'd20;
    localparam logic [PS_W-1:0] RST_PHASE_STEP     = 32'd549756;
    localparam logic [M_W-1:0]  RST_PEAK_RATIO     = 16'd11585;
    localparam logic [ZB_W-1:0] RST_ZERO_BAND      = 15'd1;

endpackage

/* design/spwm_delay.sv */
module spwm_delay #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 1
) (
    input  logic             clk,
    input  logic             en,
    input  logic [WIDTH-1:0] d,
    output logic [WIDTH-1:0] q
);

    logic [WIDTH-1:0] tap_reg [DEPTH];

    // Shift line that advances with the pipeline.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            tap_reg[0] <= d;
            for (int i = 1; i < DEPTH; i++)
            begin
                tap_reg[i] <= tap_reg[i-1];
            end
        end
    end

    assign q = tap_reg[DEPTH-1];

endmodule

/* design/spwm_sine_rom.sv */
module spwm_sine_rom #(
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     en,
    input  logic [$clog2(DEPTH)-1:0] k,
    output logic [14:0]              mag,
    output logic                     neg
);

    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

    // Quarter-wave folded sine with a Q30 Taylor series, rounded to Q1.15.
    function automatic logic [15:0] sine_entry(input int unsigned idx);
        logic [63:0] u;
        logic [63:0] q;
        logic [63:0] r;
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] term;
        logic [63:0] sum;
        logic [63:0] m;
        logic        sgn;
        u = 64'(idx) * 64'd4;
        q = u / DEPTH;
        r = u % DEPTH;
        if (q[0])
        begin
            r = 64'(DEPTH) - r;
        end
        sgn = (q >= 64'd2);
        x = (r * HALF_PI_Q30) / DEPTH;
        x2 = (x * x) >> 30;
        term = x;
        sum = x;
        term = ((term * x2) >> 30) / 6;
        sum = sum - term;
        term = ((term * x2) >> 30) / 20;
        sum = sum + term;
        term = ((term * x2) >> 30) / 42;
        sum = sum - term;
        term = ((term * x2) >> 30) / 72;
        sum = sum + term;
        term = ((term * x2) >> 30) / 110;
        sum = sum - term;
        term = ((term * x2) >> 30) / 156;
        sum = sum + term;
        term = ((term * x2) >> 30) / 210;
        sum = sum - term;
        if (sum[63])
        begin
            sum = '0;
        end
        m = (sum * 64'd32767 + (64'd1 << 29)) >> 30;
        if (m > 64'd32767)
        begin
            m = 64'd32767;
        end
        return {sgn, m[14:0]};
    endfunction

    logic [15:0] rom_tab [DEPTH];
    logic [15:0] entry_reg;

    for (genvar g = 0; g < DEPTH; g++)
    begin : g_rom
        assign rom_tab[g] = sine_entry(g);
    end

    // Registered table read.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            entry_reg <= rom_tab[k];
        end
    end

    assign mag = entry_reg[14:0];
    assign neg = entry_reg[15];

endmodule

/* design/spwm_sqrt_pipe.sv */
module spwm_sqrt_pipe #(
    parameter int VW   = 56,
    parameter int STEP = 2
) (
    input  logic              clk,
    input  logic              en,
    input  logic [VW-1:0]     v,
    output logic [VW/2-1:0]   root
);

    localparam int IT = VW / 2;
    localparam int NS = (IT + STEP - 1) / STEP;

    logic [VW-1:0] v_reg    [NS];
    logic [VW-1:0] res_reg  [NS];
    logic [VW-1:0] v_next   [NS];
    logic [VW-1:0] res_next [NS];

    // Digit-by-digit square root, STEP result bits per stage.
    always_comb
    begin
        logic [VW-1:0] a;
        logic [VW-1:0] res;
        logic [VW-1:0] b;
        logic [VW-1:0] tr;
        for (int s = 0; s < NS; s++)
        begin
            if (s == 0)
            begin
                a   = v;
                res = '0;
            end
            else
            begin
                a   = v_reg[s-1];
                res = res_reg[s-1];
            end
            for (int i = 0; i < STEP; i++)
            begin
                if (s * STEP + i < IT)
                begin
                    b  = VW'(1) << (VW - 2 - 2 * (s * STEP + i));
                    tr = res + b;
                    if (a >= tr)
                    begin
                        a   = a - tr;
                        res = (res >> 1) + b;
                    end
                    else
                    begin
                        res = res >> 1;
                    end
                end
            end
            v_next[s]   = a;
            res_next[s] = res;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int s = 0; s < NS; s++)
            begin
                v_reg[s]   <= v_next[s];
                res_reg[s] <= res_next[s];
            end
        end
    end

    assign root = res_reg[NS-1][IT-1:0];

endmodule

/* design/spwm_div_pipe.sv */
module spwm_div_pipe #(
    parameter int N    = 32,
    parameter int DW   = 16,
    parameter int STEP = 4
) (
    input  logic          clk,
    input  logic          en,
    input  logic [N-1:0]  dividend,
    input  logic [DW-1:0] divisor,
    output logic [N-1:0]  quot,
    output logic [DW-1:0] rem
);

    localparam int NS = (N + STEP - 1) / STEP;
    localparam int NP = NS * STEP;

    logic [DW-1:0] rem_reg  [NS];
    logic [NP-1:0] dq_reg   [NS];
    logic [DW-1:0] dv_reg   [NS];
    logic [DW-1:0] rem_next [NS];
    logic [NP-1:0] dq_next  [NS];

    // Restoring division, STEP quotient bits per stage. The dividend shifts
    // out of the top of dq while quotient bits shift in at the bottom.
    always_comb
    begin
        logic [DW:0]   part;
        logic [DW-1:0] r;
        logic [NP-1:0] dq;
        logic [DW-1:0] dv;
        for (int s = 0; s < NS; s++)
        begin
            if (s == 0)
            begin
                r  = '0;
                dq = NP'(dividend);
                dv = divisor;
            end
            else
            begin
                r  = rem_reg[s-1];
                dq = dq_reg[s-1];
                dv = dv_reg[s-1];
            end
            for (int i = 0; i < STEP; i++)
            begin
                part = {r, dq[NP-1]};
                dq   = {dq[NP-2:0], 1'b0};
                if (part >= {1'b0, dv})
                begin
                    part  = part - {1'b0, dv};
                    dq[0] = 1'b1;
                end
                r = part[DW-1:0];
            end
            rem_next[s] = r;
            dq_next[s]  = dq;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int s = 0; s < NS; s++)
            begin
                rem_reg[s] <= rem_next[s];
                dq_reg[s]  <= dq_next[s];
                dv_reg[s]  <= (s == 0) ? divisor : dv_reg[s-1];
            end
        end
    end

    assign quot = dq_reg[NS-1][N-1:0];
    assign rem  = rem_reg[NS-1];

endmodule

/* design/sepic_spwm_gate_generator_core.sv */
// Sinusoidal PWM gate generator for a five-switch SEPIC inverter.
//
// Input channel: one beat carries time_tick, an absolute tick count. Output
// channel: one beat carries the five gate bits, the clamped duty (Q0.16) and
// the polarity for that tick. Every input beat yields exactly one output beat.
// Both channels use valid/stall; a beat moves when valid is high and stall low.
//
// The block is a fixed-depth pipeline that takes one beat per clock while the
// output is not stalled. Its stages, in order: four stages up to the
// modulation index, the square root (two root bits per stage), the numerator,
// the duty divide (four quotient bits per stage), then clamp, on-time and the
// output register; the tick modulo carrier runs in parallel.
// When the receiver stalls a full output stage, every stage holds and
// in_stall rises in the same cycle; nothing is dropped or repeated.
//
// Reset clears all valid bits and loads the configuration defaults. The
// configuration registers are written through cfg_we/cfg_index/cfg_data and
// must only change while the pipeline is empty. Unknown indexes are ignored.
module sepic_spwm_gate_generator_core #(
    parameter int SINE_DEPTH = spwm_pkg::DEF_SINE_DEPTH,
    parameter int TICK_WIDTH = spwm_pkg::DEF_TICK_WIDTH
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic [TICK_WIDTH-1:0]            time_tick,
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic                             gate_s1,
    output logic                             gate_s2,
    output logic                             gate_s3,
    output logic                             gate_s4,
    output logic                             gate_s5,
    output logic [spwm_pkg::DUTY_W-1:0]      duty,
    output logic [spwm_pkg::POL_W-1:0]       polarity,
    input  logic                             cfg_we,
    input  logic [spwm_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [spwm_pkg::CFG_DATA_W-1:0]  cfg_data
);

    import spwm_pkg::*;

    localparam int KW     = $clog2(SINE_DEPTH);
    localparam int LS     = (SQ_VW / 2 + SQRT_STEP - 1) / SQRT_STEP;
    localparam int LD     = (NUM_W + DIV_STEP - 1) / DIV_STEP;
    localparam int LM     = (TICK_WIDTH + DIV_STEP - 1) / DIV_STEP;
    localparam int LV_M    = 4;
    localparam int LV_ROOT = LV_M + LS;
    localparam int LV_N    = LV_ROOT + 1;
    localparam int LV_QUOT = LV_N + LD;
    localparam int LV_DUTY = LV_QUOT + 1;
    localparam int LV_TON  = LV_DUTY + 1;
    localparam int LAT     = LV_TON + 1;

    // Configuration registers.
    logic [CP_W-1:0] carrier_period_reg;
    logic [CP_W-1:0] dead_time_reg;
    logic [CP_W-1:0] s1_delay_reg;
    logic [PS_W-1:0] phase_step_reg;
    logic [M_W-1:0]  peak_ratio_reg;
    logic [ZB_W-1:0] zero_band_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            carrier_period_reg <= RST_CARRIER_PERIOD;
            dead_time_reg      <= RST_DEAD_TIME;
            s1_delay_reg       <= RST_S1_DELAY;
            phase_step_reg     <= RST_PHASE_STEP;
            peak_ratio_reg     <= RST_PEAK_RATIO;
            zero_band_reg      <= RST_ZERO_BAND;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_CARRIER_PERIOD: carrier_period_reg <= cfg_data[CP_W-1:0];
                CFG_DEAD_TIME:      dead_time_reg      <= cfg_data[CP_W-1:0];
                CFG_S1_DELAY:       s1_delay_reg       <= cfg_data[CP_W-1:0];
                CFG_PHASE_STEP:     phase_step_reg     <= cfg_data[PS_W-1:0];
                CFG_PEAK_RATIO:     peak_ratio_reg     <= cfg_data[M_W-1:0];
                CFG_ZERO_BAND:      zero_band_reg      <= cfg_data[ZB_W-1:0];
                default:            ;
            endcase
        end
    end

    // Global pipeline enable: everything moves unless a finished beat is held.
    logic advance;
    logic [LAT-1:0] valid_reg;

    assign advance  = !(valid_reg[LAT-1] && out_stall);
    assign in_stall = !advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (advance)
        begin
            valid_reg <= {valid_reg[LAT-2:0], in_valid};
        end
    end

    // Stage 1: partial products of tick times phase_step.
    logic [TICK_EXT_W-1:0]          tick_ext;
    logic [LOW_BITS+PS_W-1:0]       plo_next;
    logic [2*LOW_BITS-1:0]          phi_prod;
    logic [LOW_BITS+PS_W-1:0]       plo_reg;
    logic [LOW_BITS-1:0]            phi_reg;
    logic [TICK_WIDTH-1:0]          tick_a_reg;

    assign tick_ext = TICK_EXT_W'(time_tick);
    assign plo_next = (LOW_BITS+PS_W)'(tick_ext[LOW_BITS-1:0])
                      * (LOW_BITS+PS_W)'(phase_step_reg);
    assign phi_prod = tick_ext[2*LOW_BITS-1:LOW_BITS] * phase_step_reg[LOW_BITS-1:0];

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            plo_reg    <= plo_next;
            phi_reg    <= phi_prod[LOW_BITS-1:0];
            tick_a_reg <= time_tick;
        end
    end

    // Stage 2: phase modulo 2^40 and the table index.
    logic [PHASE_BITS-1:0]   phase;
    logic [PHASE_BITS+KW:0]  kprod;
    logic [KW-1:0]           k_reg;

    assign phase = plo_reg[PHASE_BITS-1:0] + {phi_reg, {LOW_BITS{1'b0}}};
    assign kprod = (PHASE_BITS+KW+1)'(phase) * (PHASE_BITS+KW+1)'(SINE_DEPTH);

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            k_reg <= kprod[PHASE_BITS+KW-1:PHASE_BITS];
        end
    end

    // Stage 3: sine table.
    logic [MAG_W-1:0] mag_c;
    logic             neg_c;

    spwm_sine_rom #(
        .DEPTH (SINE_DEPTH)
    ) u_rom (
        .clk (clk),
        .en  (advance),
        .k   (k_reg),
        .mag (mag_c),
        .neg (neg_c)
    );

    // Stage 4: modulation index and polarity.
    logic [M_W+MAG_W-1:0] mprod;
    logic [POL_W-1:0]     pol_next;
    logic [M_W-1:0]       m_reg;
    logic [POL_W-1:0]     pol_reg;

    assign mprod = peak_ratio_reg * mag_c;

    always_comb
    begin
        if (mag_c == '0 || mag_c < zero_band_reg)
        begin
            pol_next = POL_ZERO;
        end
        else if (neg_c)
        begin
            pol_next = POL_NEG;
        end
        else
        begin
            pol_next = POL_POS;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            m_reg   <= mprod[M_W+MAG_W-1:MAG_W];
            pol_reg <= pol_next;
        end
    end

    // Square root of 1 + 4M in Q24.
    logic [SQ_VW-1:0]  sq_in;
    logic [ROOT_W-1:0] root;
    logic [M_W-1:0]    m_s;

    assign sq_in = {1'b0, 19'd4096 + {1'b0, m_reg, 2'b00}, 36'd0};

    spwm_sqrt_pipe #(
        .VW   (SQ_VW),
        .STEP (SQRT_STEP)
    ) u_sqrt (
        .clk  (clk),
        .en   (advance),
        .v    (sq_in),
        .root (root)
    );

    spwm_delay #(
        .WIDTH (M_W),
        .DEPTH (LS)
    ) u_dly_m (
        .clk (clk),
        .en  (advance),
        .d   (m_reg),
        .q   (m_s)
    );

    // Numerator of the duty formula, scaled by eight.
    logic [NUM_W-1:0] num;
    logic [NUM_W-1:0] dvd_reg;
    logic [M_W-1:0]   dvs_reg;
    logic             mz_reg;

    assign num = NUM_W'(32'd1 << 24) + (NUM_W'(m_s) << 13) - NUM_W'(root);

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            dvd_reg <= num << 3;
            dvs_reg <= m_s;
            mz_reg  <= (m_s == '0);
        end
    end

    // Duty divide.
    logic [NUM_W-1:0] quot;
    logic [M_W-1:0]   div_rem;
    logic             mz_q;

    spwm_div_pipe #(
        .N    (NUM_W),
        .DW   (M_W),
        .STEP (DIV_STEP)
    ) u_div_duty (
        .clk      (clk),
        .en       (advance),
        .dividend (dvd_reg),
        .divisor  (dvs_reg),
        .quot     (quot),
        .rem      (div_rem)
    );

    spwm_delay #(
        .WIDTH (1),
        .DEPTH (LD)
    ) u_dly_mz (
        .clk (clk),
        .en  (advance),
        .d   (mz_reg),
        .q   (mz_q)
    );

    // Clamp the duty; a zero index gives zero duty.
    logic [DUTY_W-1:0] duty_q_reg;

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            if (mz_q)
            begin
                duty_q_reg <= '0;
            end
            else if (quot > NUM_W'(DUTY_MAX))
            begin
                duty_q_reg <= DUTY_MAX;
            end
            else
            begin
                duty_q_reg <= quot[DUTY_W-1:0];
            end
        end
    end

    // On-time in Q16 ticks.
    logic [TON_W-1:0]  ton_reg;
    logic [DUTY_W-1:0] duty_t_reg;

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            ton_reg    <= duty_q_reg * carrier_period_reg;
            duty_t_reg <= duty_q_reg;
        end
    end

    // Carrier position runs beside the duty path.
    logic [TICK_WIDTH-1:0] tick_quot;
    logic [CP_W-1:0]       pos_m;
    logic [CP_W-1:0]       pos_t;
    logic [POL_W-1:0]      pol_t;

    spwm_div_pipe #(
        .N    (TICK_WIDTH),
        .DW   (CP_W),
        .STEP (DIV_STEP)
    ) u_div_pos (
        .clk      (clk),
        .en       (advance),
        .dividend (tick_a_reg),
        .divisor  (carrier_period_reg),
        .quot     (tick_quot),
        .rem      (pos_m)
    );

    spwm_delay #(
        .WIDTH (CP_W),
        .DEPTH (LV_TON - 1 - LM)
    ) u_dly_pos (
        .clk (clk),
        .en  (advance),
        .d   (pos_m),
        .q   (pos_t)
    );

    spwm_delay #(
        .WIDTH (POL_W),
        .DEPTH (LV_TON - LV_M)
    ) u_dly_pol (
        .clk (clk),
        .en  (advance),
        .d   (pol_reg),
        .q   (pol_t)
    );

    // Gate rules for the half cycle.
    logic [CP_W-1:0]  pos;
    logic [TON_W-1:0] pos16;
    logic [TON_W:0]   ton_td;
    logic             in_on;
    logic             after_off;
    logic             s1_ok;
    logic [4:0]       gates_next;

    assign pos       = (carrier_period_reg == '0) ? '0 : pos_t;
    assign pos16     = {pos, 16'd0};
    assign ton_td    = (TON_W+1)'(ton_reg) + (TON_W+1)'({dead_time_reg, 16'd0});
    assign in_on     = (pos > dead_time_reg) && (pos16 < ton_reg);
    assign after_off = (TON_W+1)'(pos16) > ton_td;
    assign s1_ok     = (17'(pos) > 17'(dead_time_reg) + 17'(s1_delay_reg));

    // Bit order: {s5, s4, s3, s2, s1}.
    always_comb
    begin
        case (pol_t)
            POL_POS:
            begin
                gates_next = {!in_on && after_off, 1'b1, 1'b0, in_on, 1'b0};
            end
            POL_NEG:
            begin
                gates_next = {!in_on || s1_ok, !in_on && after_off, in_on, 1'b0,
                              in_on && s1_ok};
            end
            default:
            begin
                gates_next = '0;
            end
        endcase
    end

    // Output register.
    logic [4:0]        gates_reg;
    logic [DUTY_W-1:0] duty_reg;
    logic [POL_W-1:0]  pol_o_reg;

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            gates_reg <= gates_next;
            duty_reg  <= duty_t_reg;
            pol_o_reg <= pol_t;
        end
    end

    assign out_valid = valid_reg[LAT-1];
    assign gate_s1   = gates_reg[0];
    assign gate_s2   = gates_reg[1];
    assign gate_s3   = gates_reg[2];
    assign gate_s4   = gates_reg[3];
    assign gate_s5   = gates_reg[4];
    assign duty      = duty_reg;
    assign polarity  = pol_o_reg;

    // The zero band drives every gate low.
    a_zero_band_off: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && polarity == POL_ZERO |->
            !(gate_s1 || gate_s2 || gate_s3 || gate_s4 || gate_s5))
        else $error("gate active in zero band");

    // The duty clamp holds at the output.
    a_duty_clamp: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> duty <= DUTY_MAX)
        else $error("duty above clamp");

    // The positive half keeps S4 on and S1, S3 off.
    a_pos_half: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && polarity == POL_POS |-> gate_s4 && !gate_s1 && !gate_s3)
        else $error("bad positive half gates");

    // S1 only conducts together with S3, and S2 never with S3.
    a_s1_with_s3: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (!gate_s1 || gate_s3) && !(gate_s2 && gate_s3))
        else $error("S1/S2/S3 overlap rule broken");

endmodule

/* tb/sv/sepic_spwm_gate_generator_checker.sv */
module sepic_spwm_gate_generator_checker
    import spwm_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    input  logic                  in_stall,
    input  logic [31:0]           time_tick,
    input  logic                  out_valid,
    input  logic                  out_stall,
    input  logic                  gate_s1,
    input  logic                  gate_s2,
    input  logic                  gate_s3,
    input  logic                  gate_s4,
    input  logic                  gate_s5,
    input  logic [DUTY_W-1:0]     duty,
    input  logic [POL_W-1:0]      polarity,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output int                    fail_count,
    output int                    pending_count
);

    typedef struct packed {
        logic [4:0]        gates;
        logic [DUTY_W-1:0] duty;
        logic [POL_W-1:0]  pol;
    } gate_beat_t;

    localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
    localparam int DEPTH = DEF_SINE_DEPTH;

    // Shadow copy of the configuration registers.
    logic [15:0] period_q;
    logic [15:0] dead_q;
    logic [15:0] s1_delay_q;
    logic [31:0] step_q;
    logic [15:0] ratio_q;
    logic [14:0] band_q;

    gate_beat_t gate_queue[$];

    assign pending_count = gate_queue.size();

    // Quarter-wave folded Taylor sine magnitude, Q1.15.
    function automatic longint unsigned sine_mag(input longint unsigned idx,
                                                 output bit is_neg);
        longint unsigned u, q, r, x, x2, term, mag;
        longint signed acc;
        u = idx * 4;
        q = u / DEPTH;
        r = u % DEPTH;
        if (q[0])
            r = DEPTH - r;
        is_neg = (q >= 2);
        x = (r * HALF_PI_Q30) / DEPTH;
        x2 = (x * x) >> 30;
        term = x;
        acc = x;
        for (int n = 1; n <= 7; n++)
        begin
            term = ((term * x2) >> 30) / longint'((2 * n) * (2 * n + 1));
            if (n % 2 == 1)
                acc -= term;
            else
                acc += term;
        end
        if (acc < 0)
            acc = 0;
        mag = (longint'(acc) * 32767 + (64'd1 << 29)) >> 30;
        if (mag > 32767)
            mag = 32767;
        return mag;
    endfunction

    function automatic longint unsigned int_sqrt(input longint unsigned v);
        longint unsigned res, b;
        res = 0;
        b = 64'd1 << 62;
        while (b > v)
            b >>= 2;
        while (b != 0)
        begin
            if (v >= res + b)
            begin
                v -= res + b;
                res = (res >> 1) + b;
            end
            else
                res >>= 1;
            b >>= 2;
        end
        return res;
    endfunction

    // Gate pattern, duty and polarity for one tick.
    function automatic gate_beat_t predict_gates(input logic [31:0] tick);
        gate_beat_t res;
        longint unsigned lo, hi, phase, idx, mag, m, dcy, pos, ton, root, num;
        bit is_neg;
        logic [4:0] g;
        lo = tick[19:0];
        hi = {52'd0, tick[31:20]};
        phase = ((lo * step_q) + (((hi * step_q) & 64'hFFFFF) << 20)) & 64'hFF_FFFF_FFFF;
        idx = (phase * DEPTH) >> 40;
        mag = sine_mag(idx, is_neg);
        m = (ratio_q * mag) >> 15;
        dcy = 0;
        if (m != 0)
        begin
            root = int_sqrt((64'd4096 + 4 * m) << 36);
            num = (64'd1 << 24) + (m << 13) - root;
            dcy = (num << 3) / m;
            if (dcy > DUTY_MAX)
                dcy = DUTY_MAX;
        end
        if (period_q == 0)
        begin
            pos = 0;
            ton = 0;
        end
        else
        begin
            pos = tick % period_q;
            ton = dcy * period_q;
        end
        // Gates are packed s5..s1 from msb to lsb.
        g = '0;
        if (mag == 0 || mag < band_q)
            res.pol = POL_ZERO;
        else if (!is_neg)
        begin
            res.pol = POL_POS;
            g[3] = 1'b1;
            if (pos > dead_q && (pos << 16) < ton)
                g[1] = 1'b1;
            else if ((pos << 16) > ton + (longint'(dead_q) << 16))
                g[4] = 1'b1;
        end
        else
        begin
            res.pol = POL_NEG;
            g[4] = 1'b1;
            if (pos > dead_q && (pos << 16) < ton)
            begin
                g[2] = 1'b1;
                if (pos > longint'(dead_q) + s1_delay_q)
                    g[0] = 1'b1;
                else
                    g[4] = 1'b0;
            end
            else if ((pos << 16) > ton + (longint'(dead_q) << 16))
                g[3] = 1'b1;
        end
        res.gates = g;
        res.duty = dcy[15:0];
        return res;
    endfunction

    task automatic report_mismatch(input string what, input longint got,
                                   input longint want);
        $display("mismatch %s: got %0d, expected %0d at %0t", what, got, want, $time);
        fail_count++;
    endtask

    // Register writes, input beats and output beats.
    always @(posedge clk or negedge rst_n)
    begin
        gate_beat_t want;
        logic [4:0] got_gates;
        if (!rst_n)
        begin
            period_q   <= RST_CARRIER_PERIOD;
            dead_q     <= RST_DEAD_TIME;
            s1_delay_q <= RST_S1_DELAY;
            step_q     <= RST_PHASE_STEP;
            ratio_q    <= RST_PEAK_RATIO;
            band_q     <= RST_ZERO_BAND;
            fail_count = 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_CARRIER_PERIOD: period_q <= cfg_data[15:0];
                    CFG_DEAD_TIME:      dead_q <= cfg_data[15:0];
                    CFG_S1_DELAY:       s1_delay_q <= cfg_data[15:0];
                    CFG_PHASE_STEP:     step_q <= cfg_data;
                    CFG_PEAK_RATIO:     ratio_q <= cfg_data[15:0];
                    CFG_ZERO_BAND:      band_q <= cfg_data[14:0];
                    default: ;
                endcase
            end
            if (in_valid && !in_stall)
                gate_queue.push_back(predict_gates(time_tick));
            if (out_valid && !out_stall)
            begin
                if (gate_queue.size() == 0)
                begin
                    $display("unexpected output beat at %0t", $time);
                    fail_count++;
                end
                else
                begin
                    want = gate_queue.pop_front();
                    got_gates = {gate_s5, gate_s4, gate_s3, gate_s2, gate_s1};
                    for (int i = 0; i < 5; i++)
                        if (got_gates[i] !== want.gates[i])
                            report_mismatch($sformatf("gate_s%0d", i + 1),
                                            got_gates[i], want.gates[i]);
                    if (duty !== want.duty)
                        report_mismatch("duty", duty, want.duty);
                    if (polarity !== want.pol)
                        report_mismatch("polarity", polarity, want.pol);
                end
            end
        end
    end

endmodule

/* tb/sv/sepic_spwm_gate_generator_core_test.sv */
module sepic_spwm_gate_generator_core_test;
    import spwm_pkg::*;

    localparam int LATENCY_WAIT = 80;
    localparam int CYCLE_LIMIT = 400000;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  in_valid = 1'b0;
    logic                  in_stall;
    logic [31:0]           time_tick = '0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    logic                  gate_s1, gate_s2, gate_s3, gate_s4, gate_s5;
    logic [DUTY_W-1:0]     duty;
    logic [POL_W-1:0]      polarity;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    int                    fail_count;
    int                    pending_count;
    int                    cycle_count = 0;
    logic [31:0]           sweep_tick = '0;

    sepic_spwm_gate_generator_core i_dut (.*);

    sepic_spwm_gate_generator_checker i_checker (.*);

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Watchdog on the total run length.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("sepic_spwm_gate_generator_core_test: errors");
            $finish;
        end
    end

    function automatic int gap_length();
        if ($urandom_range(9) < 7)
            return 0;
        if ($urandom_range(9) < 8)
            return $urandom_range(3);
        return $urandom_range(30);
    endfunction

    // Receiver stalls, with quiet stretches.
    initial
    begin
        int n;
        forever
        begin
            n = gap_length();
            repeat (n)
            begin
                @(posedge clk);
                out_stall <= 1'b1;
            end
            @(posedge clk);
            out_stall <= 1'b0;
            if ($urandom_range(7) == 0)
                repeat ($urandom_range(60)) @(posedge clk);
        end
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // Send one tick beat, holding it until accepted. Valid stays high after
    // the accepting edge so that the next beat can follow with no gap.
    task automatic send_tick(input logic [31:0] tick);
        int n;
        n = gap_length();
        if (n > 0)
        begin
            in_valid <= 1'b0;
            repeat (n) @(posedge clk);
        end
        in_valid <= 1'b1;
        time_tick <= tick;
        do
            @(posedge clk);
        while (in_stall);
    endtask

    // Wait until the pipeline has drained.
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_count != 0)
            @(posedge clk);
        repeat (LATENCY_WAIT) @(posedge clk);
    endtask

    task automatic random_config(input int style);
        logic [15:0] period;
        case (style)
            0: period = 16'd2;
            1: period = 16'hFFFF;
            2: period = 16'd0;
            default: period = $urandom_range(20) == 0 ? 16'($urandom) : 16'($urandom_range(2, 300));
        endcase
        write_reg(CFG_CARRIER_PERIOD, 32'({$urandom, period}));
        write_reg(CFG_DEAD_TIME, style == 1 ? 32'hFFFF : $urandom_range(0, period / 3 + 1));
        write_reg(CFG_S1_DELAY, style == 1 ? 32'hFFFF : $urandom_range(0, period / 3 + 1));
        write_reg(CFG_PHASE_STEP, style == 0 ? 32'hFFFF_FFFF : $urandom);
        write_reg(CFG_PEAK_RATIO, style == 0 ? 32'h0 : (style == 1 ? 32'hFFFF : $urandom));
        write_reg(CFG_ZERO_BAND, style == 1 ? 32'h7FFF : $urandom_range(0, 3000));
        write_reg(3'd7, $urandom);
    endtask

    initial
    begin
        logic [31:0] tick;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part at reset settings: tick extremes and sine landmarks.
        send_tick(32'd0);
        send_tick(32'hFFFF_FFFF);
        send_tick(32'd1999);
        send_tick(32'd2000);
        send_tick(32'd500_000);
        send_tick(32'd1_000_000);
        send_tick(32'd1_500_000);
        send_tick(32'd1_000_031);
        send_tick(32'd1_000_051);
        send_tick(32'd3_000_031);
        send_tick(32'd3_000_052);
        send_tick(32'd3_001_900);
        send_tick(32'h0010_0000);
        drain();
        // Tiny carrier period with zero peak ratio, the largest settings and a zero carrier period.
        for (int style = 0; style < 3; style++)
        begin
            random_config(style);
            for (int i = 0; i < 4; i++)
                send_tick($urandom);
            send_tick(32'hFFFF_FFFF);
            drain();
        end

        // Random phases: runs of closely spaced ticks sweep the carrier.
        for (int ph = 0; ph < 16; ph++)
        begin
            random_config(3);
            sweep_tick = $urandom;
            for (int i = 0; i < 50; i++)
            begin
                if ($urandom_range(5) == 0)
                    tick = $urandom;
                else
                begin
                    sweep_tick = sweep_tick + $urandom_range(1, 7);
                    tick = sweep_tick;
                end
                send_tick(tick);
            end
            drain();
        end

        if (fail_count == 0)
            $display("sepic_spwm_gate_generator_core_test: clean");
        else
            $display("sepic_spwm_gate_generator_core_test: errors");
        $finish;
    end

endmodule

/* files.f */
design/spwm_pkg.sv
design/spwm_delay.sv
design/spwm_sine_rom.sv
design/spwm_sqrt_pipe.sv
design/spwm_div_pipe.sv
design/sepic_spwm_gate_generator_core.sv
tb/sv/sepic_spwm_gate_generator_checker.sv
tb/sv/sepic_spwm_gate_generator_core_test.sv
